// File: hdl/paged_byte_memory_unit_macros.svh
// Assertion macros for the paged byte memory unit.
`ifndef PAGED_BYTE_MEMORY_UNIT_MACROS_SVH
`define PAGED_BYTE_MEMORY_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define PBM_ASSERT_SAME(label, cond, consq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (consq)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define PBM_ASSERT_NEXT(label, cond, consq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (consq)) else $error(msg);

`endif

// File: hdl/pbm_pkg.sv
// Shared types, widths and codes of the paged byte memory unit.
`timescale 1ns / 1ps
package pbm_pkg;

    localparam int ADDR_W      = 16;
    localparam int FRAME_W     = 8;
    localparam int PIDX_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int PHYS_OUT_W  = 12;
    localparam int STATUS_W    = 2;
    localparam int REQ_W       = 2;
    localparam int SHIFT_W     = 4;
    localparam int COUNT_W     = 9;
    localparam int SHIFT_MIN   = 4;
    localparam int SHIFT_MAX   = 12;
    localparam int PHYS_W      = FRAME_W + SHIFT_MAX;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam int DEF_MEM_BYTES = 4096;
    localparam int DEF_MAX_PAGES = 256;

    localparam logic [SHIFT_W-1:0] SHIFT_RST = SHIFT_W'(5);
    localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(128);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_MAP      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RD_LOG   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WR_LOG   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_WR_PHYS  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BEYOND   = 2'd3;

    // Register indexes (paddr bit 2)
    localparam logic REG_PAGE_SHIFT = 1'b0;
    localparam logic REG_PAGE_COUNT = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } pte_t;

endpackage

// File: hdl/pbm_ptable.sv
// Page table memory with a clearing pass after reset.
`timescale 1ns / 1ps
module pbm_ptable
    import pbm_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_PAGES)-1:0] rd_idx,
    output pte_t                         rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_PAGES)-1:0] wr_idx,
    input  pte_t                         wr_data,
    output logic                         init_done
);

    localparam int IW    = $clog2(MAX_PAGES);
    localparam int CNT_W = $clog2(MAX_PAGES + 1);

    pte_t             mem [MAX_PAGES];
    pte_t             rd_data_reg;
    logic [CNT_W-1:0] clr_cnt_reg;

    assign init_done = (clr_cnt_reg == CNT_W'(MAX_PAGES));
    assign rd_data   = rd_data_reg;

    // Sweep every entry once after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (!init_done) begin
            clr_cnt_reg <= clr_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!init_done) begin
            mem[clr_cnt_reg[IW-1:0]] <= '0;
        end else if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

endmodule

// File: hdl/pbm_store.sv
// Byte store: one access per cycle, registered read data.
`timescale 1ns / 1ps
module pbm_store
    import pbm_pkg::*;
#(
    parameter int MEM_BYTES = DEF_MEM_BYTES
) (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic                         wr_en,
    input  logic [$clog2(MEM_BYTES)-1:0] addr,
    input  logic [BYTE_W-1:0]            wdata,
    output logic [BYTE_W-1:0]            rdata
);

    logic [BYTE_W-1:0] mem [MEM_BYTES];
    logic [BYTE_W-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

endmodule

// File: hdl/paged_byte_memory_unit.sv
// Top level of the paged byte memory unit: translation, pipeline control, config.
`timescale 1ns / 1ps
`include "paged_byte_memory_unit_macros.svh"
// Usage:
//   Requests enter on the s_ valid/ready channel, one beat per request; each
//   request returns exactly one result beat on the m_ channel, in order.
//   Request codes: map page, read logical, write logical, write physical.
//   page_shift and page_count are set over the APB port (0x0 and 0x4) while
//   the unit is idle; pready is tied high, reads return the stored values.
// Pipeline and throughput:
//   The page table read issues at the edge that accepts a request. When the
//   output register is free or drains, the translated access goes to the byte
//   store and the result and m_valid are registered. One request per cycle is
//   sustained while m_ready is high; the rate is set by the single byte-store
//   port and the single page table read port. A map followed directly by an
//   access to the same page is forwarded around the page table read.
// Reset:
//   aresetn is synchronous, active low. After it the page table is swept, one
//   entry per cycle, until all MAX_PAGES entries are clear; s_ready stays low
//   meanwhile. Register writes are taken during the sweep.
// Back pressure:
//   When m_ready is low the result holds in the output register, the request
//   in the translate stage waits, and s_ready drops once that stage is full.
module paged_byte_memory_unit
    import pbm_pkg::*;
#(
    parameter int MEM_BYTES = DEF_MEM_BYTES,
    parameter int MAX_PAGES = DEF_MAX_PAGES
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    // Request channel
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [REQ_W-1:0]        s_req_type,
    input  logic [ADDR_W-1:0]       s_address,
    input  logic [PIDX_W-1:0]       s_page_index,
    input  logic [FRAME_W-1:0]      s_frame_index,
    input  logic [BYTE_W-1:0]       s_write_byte,
    // Result channel
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [BYTE_W-1:0]       m_read_byte,
    output logic [PHYS_OUT_W-1:0]   m_phys_addr,
    output logic [STATUS_W-1:0]     m_status
);

    localparam int IW  = $clog2(MAX_PAGES);
    localparam int AW  = $clog2(MEM_BYTES);
    localparam int CMP_W = PHYS_W + 1;

    // ---------------- configuration registers ----------------
    logic [SHIFT_W-1:0] page_shift_reg;
    logic [COUNT_W-1:0] page_count_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_shift_reg <= SHIFT_RST;
            page_count_reg <= COUNT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_PAGE_SHIFT: page_shift_reg <= pwdata[SHIFT_W-1:0];
                REG_PAGE_COUNT: page_count_reg <= pwdata[COUNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PAGE_SHIFT: prdata = APB_DATA_W'(page_shift_reg);
            REG_PAGE_COUNT: prdata = APB_DATA_W'(page_count_reg);
        endcase
    end

    // Clamp shift and count to their usable ranges
    logic [SHIFT_W-1:0] eff_shift;
    logic [ADDR_W-1:0]  eff_count;
    logic [ADDR_W-1:0]  count_ext;

    assign count_ext = ADDR_W'(page_count_reg);

    always_comb begin
        if (page_shift_reg < SHIFT_W'(SHIFT_MIN)) begin
            eff_shift = SHIFT_W'(SHIFT_MIN);
        end else if (page_shift_reg > SHIFT_W'(SHIFT_MAX)) begin
            eff_shift = SHIFT_W'(SHIFT_MAX);
        end else begin
            eff_shift = page_shift_reg;
        end
        eff_count = (count_ext > ADDR_W'(MAX_PAGES)) ? ADDR_W'(MAX_PAGES) : count_ext;
    end

    // ---------------- pipeline control ----------------
    logic                 init_done;
    logic                 a_valid_reg;
    logic                 a_fire;
    logic                 s_acc;
    logic                 m_valid_reg;

    assign a_fire  = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = init_done && (!a_valid_reg || a_fire);
    assign s_acc   = s_valid && s_ready;

    // ---------------- stage A: table read at accept ----------------
    logic [ADDR_W-1:0]  s_page;
    logic [IW-1:0]      s_tbl_idx;

    assign s_page    = s_address >> eff_shift;
    assign s_tbl_idx = IW'(s_page);

    logic [REQ_W-1:0]   a_req_reg;
    logic [ADDR_W-1:0]  a_addr_reg;
    logic [PIDX_W-1:0]  a_pidx_reg;
    logic [FRAME_W-1:0] a_fidx_reg;
    logic [BYTE_W-1:0]  a_wbyte_reg;
    logic               a_fwd_reg;
    logic [FRAME_W-1:0] a_fwd_frame_reg;

    logic               a_map_ok;
    logic [IW-1:0]      a_map_idx;
    logic               fwd_hit;

    assign a_map_idx = IW'(a_pidx_reg);
    // A map retiring in the same cycle as the table read wins over the stale read
    assign fwd_hit   = a_fire && a_map_ok && (a_map_idx == s_tbl_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_acc) begin
            a_valid_reg <= 1'b1;
        end else if (a_fire) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            a_req_reg       <= s_req_type;
            a_addr_reg      <= s_address;
            a_pidx_reg      <= s_page_index;
            a_fidx_reg      <= s_frame_index;
            a_wbyte_reg     <= s_write_byte;
            a_fwd_reg       <= fwd_hit;
            a_fwd_frame_reg <= a_fidx_reg;
        end
    end

    pte_t pt_rdata;
    pte_t pt_wdata;
    pte_t a_entry;

    assign pt_wdata = '{valid: 1'b1, frame: a_fidx_reg};
    assign a_entry  = a_fwd_reg ? pte_t'{valid: 1'b1, frame: a_fwd_frame_reg} : pt_rdata;

    pbm_ptable #(
        .MAX_PAGES (MAX_PAGES)
    ) u_ptable (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_acc),
        .rd_idx    (s_tbl_idx),
        .rd_data   (pt_rdata),
        .wr_en     (a_fire && a_map_ok),
        .wr_idx    (a_map_idx),
        .wr_data   (pt_wdata),
        .init_done (init_done)
    );

    // ---------------- stage A: translate and access ----------------
    logic [ADDR_W-1:0]   a_page;
    logic [ADDR_W-1:0]   a_offset;
    logic [PHYS_W-1:0]   a_phys_log;
    logic [PHYS_W-1:0]   a_phys;
    logic [STATUS_W-1:0] a_status;
    logic                a_rd_ok;
    logic                a_wr_ok;

    assign a_page     = a_addr_reg >> eff_shift;
    assign a_offset   = a_addr_reg & ((ADDR_W'(1) << eff_shift) - ADDR_W'(1));
    // offset sits below the frame bits, so OR equals add
    assign a_phys_log = (PHYS_W'(a_entry.frame) << eff_shift) | PHYS_W'(a_offset);

    always_comb begin
        a_status = ST_OK;
        a_map_ok = 1'b0;
        a_rd_ok  = 1'b0;
        a_wr_ok  = 1'b0;
        a_phys   = '0;
        unique case (a_req_reg) inside
            REQ_MAP: begin
                if (ADDR_W'(a_pidx_reg) >= eff_count) begin
                    a_status = ST_RANGE;
                end else begin
                    a_map_ok = 1'b1;
                end
            end
            REQ_WR_PHYS: begin
                if (CMP_W'(a_addr_reg) >= CMP_W'(MEM_BYTES)) begin
                    a_status = ST_BEYOND;
                end else begin
                    a_wr_ok = 1'b1;
                    a_phys  = PHYS_W'(a_addr_reg);
                end
            end
            REQ_RD_LOG, REQ_WR_LOG: begin
                if (a_page >= eff_count) begin
                    a_status = ST_RANGE;
                end else if (!a_entry.valid) begin
                    a_status = ST_UNMAPPED;
                end else if (CMP_W'(a_phys_log) >= CMP_W'(MEM_BYTES)) begin
                    a_status = ST_BEYOND;
                end else begin
                    a_phys  = a_phys_log;
                    a_rd_ok = (a_req_reg == REQ_RD_LOG);
                    a_wr_ok = (a_req_reg == REQ_WR_LOG);
                end
            end
        endcase
    end

    logic              st_rd_en;
    logic              st_wr_en;
    logic [BYTE_W-1:0] st_rdata;

    assign st_rd_en = a_fire && a_rd_ok;
    assign st_wr_en = a_fire && a_wr_ok;

    pbm_store #(
        .MEM_BYTES (MEM_BYTES)
    ) u_store (
        .aclk  (aclk),
        .rd_en (st_rd_en),
        .wr_en (st_wr_en),
        .addr  (AW'(a_phys)),
        .wdata (a_wbyte_reg),
        .rdata (st_rdata)
    );

    // ---------------- output register ----------------
    logic                  m_is_read_reg;
    logic [PHYS_OUT_W-1:0] m_phys_reg;
    logic [STATUS_W-1:0]   m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Hold the result while the receiver stalls; store read data holds with it
    always_ff @(posedge aclk) begin
        if (a_fire) begin
            m_is_read_reg <= a_rd_ok;
            m_phys_reg    <= a_phys[PHYS_OUT_W-1:0];
            m_status_reg  <= a_status;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_byte = m_is_read_reg ? st_rdata : '0;
    assign m_phys_addr = m_phys_reg;
    assign m_status    = m_status_reg;

    // ---------------- assertions ----------------
    `PBM_ASSERT_NEXT(a_retire_gives_result, a_fire, m_valid_reg,
        "translate stage retired without a result")
    `PBM_ASSERT_NEXT(fwd_marks_valid, s_acc && fwd_hit && (s_req_type != REQ_MAP),
        a_entry.valid, "forwarded page table entry is not valid")
    `PBM_ASSERT_SAME(fault_no_store, a_fire && (a_status != ST_OK), !st_wr_en && !st_rd_en,
        "faulting request touched the byte store")

endmodule

// File: tb/tb_paged_byte_memory_unit.sv
// Self-checking testbench for the paged byte memory unit: directed and random requests.
`timescale 1ns / 1ps
module tb_paged_byte_memory_unit;
    import pbm_pkg::*;

    localparam int ITEMS_PER_PHASE = 180;
    localparam int NUM_PHASES      = 7;
    localparam int REPORT_LIMIT    = 10;

    // One result beat as the unit should return it.
    typedef struct {
        logic [BYTE_W-1:0]     rd;
        logic [PHYS_OUT_W-1:0] phys;
        logic [STATUS_W-1:0]   st;
    } access_result_t;

    // Mirror of the page table, byte store and registers; holds the results still owed.
    class translation_tracker;
        logic [SHIFT_W-1:0] shift_reg;
        logic [COUNT_W-1:0] count_reg;
        bit                 entry_valid[DEF_MAX_PAGES];
        logic [FRAME_W-1:0] entry_frame[DEF_MAX_PAGES];
        logic [BYTE_W-1:0]  byte_store[DEF_MEM_BYTES];
        bit                 byte_written[DEF_MEM_BYTES];
        access_result_t     owed[$];
        int                 fail_count;

        function new();
            shift_reg  = SHIFT_RST;
            count_reg  = COUNT_RST;
            fail_count = 0;
            foreach (entry_valid[i]) entry_valid[i] = 1'b0;
            foreach (byte_written[i]) byte_written[i] = 1'b0;
        endfunction

        function void set_reg(logic sel, logic [APB_DATA_W-1:0] value);
            if (sel == REG_PAGE_SHIFT) shift_reg = value[SHIFT_W-1:0];
            else count_reg = value[COUNT_W-1:0];
        endfunction

        // Clamp the shift into the supported page sizes.
        function int page_bits();
            if (shift_reg < SHIFT_MIN) return SHIFT_MIN;
            if (shift_reg > SHIFT_MAX) return SHIFT_MAX;
            return int'(shift_reg);
        endfunction

        function int page_limit();
            return (count_reg > DEF_MAX_PAGES) ? DEF_MAX_PAGES : int'(count_reg);
        endfunction

        function logic [STATUS_W-1:0] translate(input logic [ADDR_W-1:0] addr,
                                                output logic [PHYS_OUT_W-1:0] phys);
            int sh;
            int page;
            int offset;
            int p;
            sh     = page_bits();
            page   = int'(addr) >> sh;
            offset = int'(addr) & ((1 << sh) - 1);
            phys   = '0;
            if (page >= page_limit()) return ST_RANGE;
            if (!entry_valid[page]) return ST_UNMAPPED;
            p = (int'(entry_frame[page]) << sh) + offset;
            if (p >= DEF_MEM_BYTES) return ST_BEYOND;
            phys = PHYS_OUT_W'(p);
            return ST_OK;
        endfunction

        // Apply an accepted request and queue the result it owes.
        function void note_request(logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr,
                                   logic [PIDX_W-1:0] pidx, logic [FRAME_W-1:0] fidx,
                                   logic [BYTE_W-1:0] wb);
            access_result_t        r;
            logic [PHYS_OUT_W-1:0] p;
            r.rd   = '0;
            r.phys = '0;
            r.st   = ST_OK;
            case (req)
                REQ_MAP: begin
                    if (int'(pidx) >= page_limit()) begin
                        r.st = ST_RANGE;
                    end else begin
                        entry_frame[pidx] = fidx;
                        entry_valid[pidx] = 1'b1;
                    end
                end
                REQ_WR_PHYS: begin
                    if (int'(addr) >= DEF_MEM_BYTES) begin
                        r.st = ST_BEYOND;
                    end else begin
                        byte_store[addr[PHYS_OUT_W-1:0]]   = wb;
                        byte_written[addr[PHYS_OUT_W-1:0]] = 1'b1;
                        r.phys = addr[PHYS_OUT_W-1:0];
                    end
                end
                default: begin
                    r.st = translate(addr, p);
                    if (r.st == ST_OK) begin
                        r.phys = p;
                        if (req == REQ_RD_LOG) begin
                            r.rd = byte_store[p];
                        end else begin
                            byte_store[p]   = wb;
                            byte_written[p] = 1'b1;
                        end
                    end
                end
            endcase
            owed.push_back(r);
        endfunction

        function void check_result(logic [BYTE_W-1:0] rd, logic [PHYS_OUT_W-1:0] phys,
                                   logic [STATUS_W-1:0] st);
            access_result_t e;
            if (owed.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result beat: read_byte=%h phys_addr=%h status=%0d",
                             rd, phys, st);
                return;
            end
            e = owed.pop_front();
            if (rd !== e.rd || phys !== e.phys || st !== e.st) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("mismatch: expected read_byte=%h phys_addr=%h status=%0d, %s%h %h %0d",
                             e.rd, e.phys, e.st, "got ", rd, phys, st);
            end
        endfunction
    endclass

    logic                    aclk          = 1'b0;
    logic                    aresetn       = 1'b0;
    logic                    psel          = 1'b0;
    logic                    penable       = 1'b0;
    logic                    pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr         = '0;
    logic [APB_DATA_W-1:0]   pwdata        = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_valid       = 1'b0;
    logic                    s_ready;
    logic [REQ_W-1:0]        s_req_type    = REQ_MAP;
    logic [ADDR_W-1:0]       s_address     = '0;
    logic [PIDX_W-1:0]       s_page_index  = '0;
    logic [FRAME_W-1:0]      s_frame_index = '0;
    logic [BYTE_W-1:0]       s_write_byte  = '0;
    logic                    m_valid;
    logic                    m_ready       = 1'b0;
    logic [BYTE_W-1:0]       m_read_byte;
    logic [PHYS_OUT_W-1:0]   m_phys_addr;
    logic [STATUS_W-1:0]     m_status;

    translation_tracker tracker = new();

    // Logical addresses written lately; reads aim at them so most reads hit real data.
    logic [ADDR_W-1:0] recent_writes[$];
    bit                send_burst = 1'b0;
    bit                recv_burst = 1'b0;

    // Shift and count per phase: clamped values on both sides, an empty table, one page.
    int phase_shift[NUM_PHASES] = '{4, 12, 0, 15, 9, 5, 4};
    int phase_count[NUM_PHASES] = '{256, 16, 511, 300, 0, 200, 1};

    paged_byte_memory_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_address     (s_address),
        .s_page_index  (s_page_index),
        .s_frame_index (s_frame_index),
        .s_write_byte  (s_write_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_byte   (m_read_byte),
        .m_phys_addr   (m_phys_addr),
        .m_status      (m_status)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Send one request beat. Call at a falling edge; returns at a falling edge.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                                input logic [PIDX_W-1:0] pidx, input logic [FRAME_W-1:0] fidx,
                                input logic [BYTE_W-1:0] wb);
        int gap;
        // Flip between idle-free bursts and randomly gapped traffic now and then.
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_address     <= addr;
        s_page_index  <= pidx;
        s_frame_index <= fidx;
        s_write_byte  <= wb;
        // Hold the beat until the unit takes it.
        do @(posedge aclk); while (s_ready !== 1'b1);
        tracker.note_request(req, addr, pidx, fidx, wb);
        @(negedge aclk);
    endtask

    // APB write: setup cycle, then access cycle; the register lands at the access edge.
    task automatic write_reg(input logic sel, input logic [APB_DATA_W-1:0] value);
        s_valid <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        tracker.set_reg(sel, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Leave the bus idle before the next transfer
        @(negedge aclk);
    endtask

    // Drop valid, wait until every owed result has come back, then let the pipeline settle.
    task automatic drain(input int settle);
        s_valid <= 1'b0;
        while (tracker.owed.size() != 0) @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    function automatic bit find_mapped_page(output int page);
        int cnt;
        cnt  = tracker.page_limit();
        page = 0;
        if (cnt == 0) return 1'b0;
        repeat (8) begin
            page = $urandom_range(0, cnt - 1);
            if (tracker.entry_valid[page]) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Draw one request: mostly well-formed maps and accesses, with some noise mixed in.
    function automatic void build_request(output logic [REQ_W-1:0] req,
                                          output logic [ADDR_W-1:0] addr,
                                          output logic [PIDX_W-1:0] pidx,
                                          output logic [FRAME_W-1:0] fidx,
                                          output logic [BYTE_W-1:0] wb);
        int                    pick;
        int                    sh;
        int                    cnt;
        int                    page;
        logic [STATUS_W-1:0]   st;
        logic [PHYS_OUT_W-1:0] phys;
        addr = ADDR_W'($urandom);
        pidx = PIDX_W'($urandom);
        fidx = FRAME_W'($urandom);
        wb   = BYTE_W'($urandom);
        sh   = tracker.page_bits();
        cnt  = tracker.page_limit();
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            req = REQ_MAP;
            if (cnt > 0 && $urandom_range(0, 9) < 8) pidx = PIDX_W'($urandom_range(0, cnt - 1));
            // Mostly frames inside the store; the rest are random and may land beyond it.
            if ($urandom_range(0, 9) < 8)
                fidx = FRAME_W'($urandom_range(0, (DEF_MEM_BYTES >> sh) - 1));
        end else if (pick < 27) begin
            req = REQ_WR_PHYS;
            if ($urandom_range(0, 9) < 9) addr = ADDR_W'($urandom_range(0, DEF_MEM_BYTES - 1));
        end else begin
            req = (pick < 60) ? REQ_WR_LOG : REQ_RD_LOG;
            if (req == REQ_RD_LOG && recent_writes.size() > 0 && $urandom_range(0, 9) < 7)
                addr = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
            else if ($urandom_range(0, 9) < 9 && find_mapped_page(page))
                addr = ADDR_W'((page << sh) | $urandom_range(0, (1 << sh) - 1));
            // Never read a byte that was never stored; write it instead.
            if (req == REQ_RD_LOG) begin
                st = tracker.translate(addr, phys);
                if (st == ST_OK && !tracker.byte_written[phys]) req = REQ_WR_LOG;
            end
            if (req == REQ_WR_LOG) begin
                recent_writes.push_back(addr);
                if (recent_writes.size() > 32) void'(recent_writes.pop_front());
            end
        end
    endfunction

    // Result side: stall at random per beat, check each accepted beat in order.
    initial begin
        int stall;
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(aresetn === 1'b1 && m_valid === 1'b1));
            tracker.check_result(m_read_byte, m_phys_addr, m_status);
            @(negedge aclk);
        end
    end

    initial begin
        logic [REQ_W-1:0]   req;
        logic [ADDR_W-1:0]  addr;
        logic [PIDX_W-1:0]  pidx;
        logic [FRAME_W-1:0] fidx;
        logic [BYTE_W-1:0]  wb;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed pass at the reset settings: 32-byte pages, 128 pages in use.
        send_request(REQ_RD_LOG, 16'h0000, 8'($urandom), 8'($urandom), 8'($urandom));
        send_request(REQ_MAP, 16'($urandom), 8'd200, 8'd3, 8'($urandom));
        send_request(REQ_MAP, 16'($urandom), 8'd0, 8'd0, 8'($urandom));
        send_request(REQ_WR_LOG, 16'h001F, 8'($urandom), 8'($urandom), 8'hFF);
        send_request(REQ_RD_LOG, 16'h001F, 8'($urandom), 8'($urandom), 8'($urandom));
        send_request(REQ_MAP, 16'($urandom), 8'd127, 8'd127, 8'($urandom));
        send_request(REQ_WR_LOG, 16'h0FFF, 8'($urandom), 8'($urandom), 8'h00);
        send_request(REQ_RD_LOG, 16'h0FFF, 8'($urandom), 8'($urandom), 8'($urandom));
        // A frame past the end of the store: accesses through it fault.
        send_request(REQ_MAP, 16'($urandom), 8'd1, 8'd255, 8'($urandom));
        send_request(REQ_WR_LOG, 16'h0020, 8'($urandom), 8'($urandom), 8'h77);
        send_request(REQ_RD_LOG, 16'h0020, 8'($urandom), 8'($urandom), 8'($urandom));
        // Remap a live page, then use it back to back.
        send_request(REQ_MAP, 16'($urandom), 8'd1, 8'd2, 8'($urandom));
        send_request(REQ_WR_LOG, 16'h0021, 8'($urandom), 8'($urandom), 8'h3C);
        send_request(REQ_RD_LOG, 16'h0021, 8'($urandom), 8'($urandom), 8'($urandom));
        send_request(REQ_WR_PHYS, 16'h0000, 8'($urandom), 8'($urandom), 8'h5A);
        send_request(REQ_RD_LOG, 16'h0000, 8'($urandom), 8'($urandom), 8'($urandom));
        send_request(REQ_WR_PHYS, 16'h0FFF, 8'($urandom), 8'($urandom), 8'hA5);
        send_request(REQ_RD_LOG, 16'h0FFF, 8'($urandom), 8'($urandom), 8'($urandom));
        send_request(REQ_WR_PHYS, 16'h1000, 8'($urandom), 8'($urandom), 8'h11);
        send_request(REQ_WR_PHYS, 16'hFFFF, 8'($urandom), 8'($urandom), 8'hEE);
        send_request(REQ_RD_LOG, 16'hFFFF, 8'($urandom), 8'($urandom), 8'($urandom));
        send_request(REQ_WR_LOG, 16'h1000, 8'($urandom), 8'($urandom), 8'h22);
        send_request(REQ_MAP, 16'($urandom), 8'd255, 8'd255, 8'($urandom));
        send_request(REQ_MAP, 16'($urandom), 8'd127, 8'd0, 8'($urandom));
        send_request(REQ_RD_LOG, 16'h0FFF, 8'($urandom), 8'($urandom), 8'($urandom));

        // Random phases; reprogram both registers only once the unit is idle.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain(4);
            write_reg(REG_PAGE_SHIFT, APB_DATA_W'(phase_shift[ph]));
            write_reg(REG_PAGE_COUNT, APB_DATA_W'(phase_count[ph]));
            recent_writes.delete();
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                build_request(req, addr, pidx, fidx, wb);
                send_request(req, addr, pidx, fidx, wb);
            end
        end

        drain(10);
        if (tracker.fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #(3_000_000);
        $display("status: fail");
        $finish;
    end

endmodule
